@@ rtl/core/burst_pulse_schedule_calc_top_macros.svh @@
// assertion macros for the burst pulse schedule block
// used by burst_pulse_schedule_calc_top, needs clk and rst in scope
`ifndef BURST_PULSE_SCHEDULE_CALC_TOP_MACROS_SVH
`define BURST_PULSE_SCHEDULE_CALC_TOP_MACROS_SVH

// same-cycle implication
`define BPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bpsc_pkg.sv @@
// shared types, constants and helpers of the burst pulse schedule block
// no dependencies
package bpsc_pkg;

  localparam int unsigned F_W    = 20;
  localparam int unsigned N_W    = 16;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned TICK_W = 22;
  localparam int unsigned RAM_W  = 16;
  localparam int unsigned RATE_W = 22;
  localparam int unsigned DVD_W  = 38;
  localparam int unsigned SF_W   = F_W + RAM_W;
  localparam int unsigned Q_W    = 23;
  localparam int unsigned Y_PAD  = DVD_W - Q_W;
  localparam int unsigned NUM_D  = 4;

  localparam logic [RAM_W-1:0] RAM_SIZE_RESET = 16'd32760;

  // distinct rates, fastest first
  localparam logic [RATE_W-1:0] RATE_D [NUM_D] = '{22'd4000000, 22'd1000000,
                                                   22'd250000, 22'd62500};
  // largest f with rate/f at least three, one bit wider than f
  localparam logic [F_W:0] F_MAX3_D [NUM_D] = '{21'd1333333, 21'd333333,
                                               21'd83333, 21'd20833};
  // exponent of the largest power of two dividing each rate
  localparam int unsigned POW2_D [NUM_D] = '{8, 6, 4, 2};
  // clock select codes for first choice and fallback
  localparam logic [SEL_W-1:0] SEL_FIRST_D [NUM_D] = '{3'd2, 3'd3, 3'd4, 3'd5};
  localparam logic [SEL_W-1:0] SEL_FALL_D  [NUM_D] = '{3'd0, 3'd3, 3'd4, 3'd5};

  localparam logic [RATE_W-1:0] POW5 [7] = '{22'd1, 22'd5, 22'd25, 22'd125,
                                             22'd625, 22'd3125, 22'd15625};

  typedef struct packed {
    logic              setup_ok;
    logic [SEL_W-1:0]  clock_sel;
    logic              index_valid;
    logic              last_pulse;
    logic [RATE_W-1:0] rate;
  } side_t;

  typedef struct packed {
    logic [F_W-1:0]   f;
    logic [F_W-1:0]   acc;
    logic [DVD_W-1:0] dvd;
    logic [Q_W-1:0]   quot;
    side_t            side;
  } stage_t;

  // f divides 2^amax * 5^6 exactly
  function automatic logic rate_divides(logic [F_W-1:0] f, int unsigned amax);
    logic hit;
    hit = 1'b0;
    for (int b = 0; b < 7; b++) begin
      for (int a = 0; a < 9; a++) begin
        if ((a <= amax) && ({2'b00, f} == (POW5[b] << a))) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

@@ rtl/core/bpsc_if.sv @@
// request and response channel interfaces of the burst pulse schedule block
// depends on bpsc_pkg for field widths
interface bpsc_req_if;
  logic                       valid;
  logic                       ready;
  logic [bpsc_pkg::F_W-1:0]   burst_freq;
  logic [bpsc_pkg::N_W-1:0]   pulse_count;
  logic [bpsc_pkg::N_W-1:0]   pulse_index;
  modport source (output valid, burst_freq, pulse_count, pulse_index, input ready);
  modport sink   (input valid, burst_freq, pulse_count, pulse_index, output ready);
endinterface

interface bpsc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        setup_ok;
  logic [bpsc_pkg::SEL_W-1:0]  clock_sel;
  logic [bpsc_pkg::TICK_W-1:0] pulse_ticks;
  logic                        index_valid;
  logic                        last_pulse;
  modport source (output valid, setup_ok, clock_sel, pulse_ticks, index_valid,
                  last_pulse, input ready);
  modport sink   (input valid, setup_ok, clock_sel, pulse_ticks, index_valid,
                  last_pulse, output ready);
endinterface

@@ rtl/core/bpsc_rate_sel.sv @@
// two-stage rate selection: products and divisibility, then choice
// depends on bpsc_pkg
module bpsc_rate_sel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic [bpsc_pkg::F_W-1:0]    burst_freq,
  input  logic [bpsc_pkg::N_W-1:0]    pulse_count,
  input  logic [bpsc_pkg::N_W-1:0]    pulse_index,
  input  logic [bpsc_pkg::RAM_W-1:0]  seq_ram_size,
  output logic                        vld_out,
  output bpsc_pkg::stage_t            stg_out
);

  localparam int unsigned ND = bpsc_pkg::NUM_D;

  // stage 1 registers
  logic                          vld1;
  logic [bpsc_pkg::F_W-1:0]      f1;
  logic                          valid1;
  logic                          last1;
  logic [bpsc_pkg::DVD_W-1:0]    rn1 [ND];
  logic [bpsc_pkg::DVD_W-1:0]    x1  [ND];
  logic [bpsc_pkg::SF_W-1:0]     sf1;
  logic [ND-1:0]                 cand1;

  logic                          idx_ok;
  logic [bpsc_pkg::N_W-1:0]      k_m1;

  assign idx_ok = (pulse_index != '0) && (pulse_index <= pulse_count);
  assign k_m1   = pulse_index - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1     <= burst_freq;
      valid1 <= idx_ok;
      last1  <= idx_ok && (pulse_index == pulse_count);
      sf1    <= bpsc_pkg::SF_W'(seq_ram_size) * bpsc_pkg::SF_W'(burst_freq);
      for (int d = 0; d < ND; d++) begin
        rn1[d]   <= bpsc_pkg::DVD_W'(pulse_count) * bpsc_pkg::DVD_W'(bpsc_pkg::RATE_D[d]);
        x1[d]    <= bpsc_pkg::DVD_W'(k_m1) * bpsc_pkg::DVD_W'(bpsc_pkg::RATE_D[d]);
        cand1[d] <= ({1'b0, burst_freq} <= bpsc_pkg::F_MAX3_D[d]) &&
                    bpsc_pkg::rate_divides(burst_freq, bpsc_pkg::POW2_D[d]);
      end
    end
  end

  // stage 2: choose the rate
  logic [ND-1:0]                 fit;
  logic                          found;
  logic [1:0]                    dsel;
  logic [bpsc_pkg::SEL_W-1:0]    sel;
  bpsc_pkg::stage_t              stg_next;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      fit[d] = rn1[d] <= {2'b00, sf1};
    end
    found = 1'b0;
    dsel  = '0;
    sel   = '0;
    // slowest exact multiple first
    for (int d = 0; d < ND; d++) begin
      if (cand1[d]) begin
        found = fit[d];
        dsel  = 2'(d);
        sel   = bpsc_pkg::SEL_FIRST_D[d];
      end
    end
    // otherwise fastest rate that fits
    if (!found) begin
      for (int d = ND - 1; d >= 0; d--) begin
        if (fit[d]) begin
          found = 1'b1;
          dsel  = 2'(d);
          sel   = bpsc_pkg::SEL_FALL_D[d];
        end
      end
    end
    if (f1 == '0) found = 1'b0;

    stg_next.f                     = f1;
    stg_next.acc                   = '0;
    stg_next.dvd                   = x1[dsel];
    stg_next.quot                  = '0;
    stg_next.side.setup_ok         = found;
    stg_next.side.clock_sel        = found ? sel : '0;
    stg_next.side.index_valid      = valid1;
    stg_next.side.last_pulse       = last1;
    stg_next.side.rate             = bpsc_pkg::RATE_D[dsel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_out <= stg_next;
    end
  end

endmodule

@@ rtl/core/bpsc_div_cell.sv @@
// one restoring division step: shift in a dividend bit, subtract if it fits
// depends on bpsc_pkg
module bpsc_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  bpsc_pkg::stage_t stg_in,
  output logic             vld_out,
  output bpsc_pkg::stage_t stg_out
);

  logic [bpsc_pkg::F_W:0]   trial;
  logic [bpsc_pkg::F_W:0]   diff;
  logic                     ge;
  bpsc_pkg::stage_t         stg_next;

  always_comb begin
    trial    = {stg_in.acc, stg_in.dvd[bpsc_pkg::DVD_W-1]};
    diff     = trial - {1'b0, stg_in.f};
    ge       = trial >= {1'b0, stg_in.f};
    stg_next = stg_in;
    stg_next.acc  = ge ? diff[bpsc_pkg::F_W-1:0] : trial[bpsc_pkg::F_W-1:0];
    stg_next.dvd  = {stg_in.dvd[bpsc_pkg::DVD_W-2:0], 1'b0};
    stg_next.quot = {stg_in.quot[bpsc_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_out <= stg_next;
    end
  end

endmodule

@@ rtl/core/burst_pulse_schedule_calc_top.sv @@
// pipeline: 2 select stages + 38 division cells + 1 reload + 23 cells + 1 output = 65 stages
// throughput: one item per cycle while not stalled; every division bit is its own cell in the chain
// the whole chain advances together and holds while a finished result is not taken
// reset (rst, synchronous, active high) clears all valid bits and sets
// seq_ram_size to 32760; payload registers are not reset
// depends on bpsc_pkg, bpsc_if, bpsc_rate_sel, bpsc_div_cell and the macros header
`include "burst_pulse_schedule_calc_top_macros.svh"

module burst_pulse_schedule_calc_top (
  input  logic                       clk,
  input  logic                       rst,
  bpsc_req_if.sink                   req,
  bpsc_rsp_if.source                 rsp,
  input  logic                       seq_ram_size_we,
  input  logic [bpsc_pkg::RAM_W-1:0] seq_ram_size_wdata
);

  localparam int unsigned N1 = bpsc_pkg::DVD_W;   // cells for (k-1)*R mod f
  localparam int unsigned N2 = bpsc_pkg::Q_W;     // cells for (rem+R)/f

  logic [bpsc_pkg::RAM_W-1:0] seq_ram_size;
  logic                       en;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_ram_size <= bpsc_pkg::RAM_SIZE_RESET;
    end else if (seq_ram_size_we) begin
      seq_ram_size <= seq_ram_size_wdata;
    end
  end

  // chain moves unless a finished result is stalled
  assign en        = !(rsp.valid && !rsp.ready);
  assign req.ready = en;

  // rate choice and (k-1)*R
  logic             sel_vld;
  bpsc_pkg::stage_t sel_stg;

  bpsc_rate_sel u_sel (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .vld_in       (req.valid),
    .burst_freq   (req.burst_freq),
    .pulse_count  (req.pulse_count),
    .pulse_index  (req.pulse_index),
    .seq_ram_size (seq_ram_size),
    .vld_out      (sel_vld),
    .stg_out      (sel_stg)
  );

  // first chain: remainder of (k-1)*R over f
  logic             c1_vld [N1+1];
  bpsc_pkg::stage_t c1_stg [N1+1];

  assign c1_vld[0] = sel_vld;
  assign c1_stg[0] = sel_stg;

  for (genvar i = 0; i < N1; i++) begin : g_c1
    bpsc_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (c1_vld[i]),
      .stg_in  (c1_stg[i]),
      .vld_out (c1_vld[i+1]),
      .stg_out (c1_stg[i+1])
    );
  end

  // reload: new dividend rem+R, top-aligned, fresh remainder
  logic                     rl_vld;
  bpsc_pkg::stage_t         rl_stg;
  logic [bpsc_pkg::Q_W-1:0] y_sum;

  assign y_sum = bpsc_pkg::Q_W'(c1_stg[N1].acc) + bpsc_pkg::Q_W'(c1_stg[N1].side.rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      rl_vld <= 1'b0;
    end else if (en) begin
      rl_vld <= c1_vld[N1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rl_stg.f    <= c1_stg[N1].f;
      rl_stg.acc  <= '0;
      rl_stg.dvd  <= {y_sum, {bpsc_pkg::Y_PAD{1'b0}}};
      rl_stg.quot <= '0;
      rl_stg.side <= c1_stg[N1].side;
    end
  end

  // second chain: quotient is the tick interval
  logic             c2_vld [N2+1];
  bpsc_pkg::stage_t c2_stg [N2+1];

  assign c2_vld[0] = rl_vld;
  assign c2_stg[0] = rl_stg;

  for (genvar i = 0; i < N2; i++) begin : g_c2
    bpsc_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (c2_vld[i]),
      .stg_in  (c2_stg[i]),
      .vld_out (c2_vld[i+1]),
      .stg_out (c2_stg[i+1])
    );
  end

  // output register; ticks forced to zero on failed setup or bad index
  bpsc_pkg::side_t out_side;

  assign out_side = c2_stg[N2].side;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= c2_vld[N2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.setup_ok    <= out_side.setup_ok;
      rsp.clock_sel   <= out_side.clock_sel;
      rsp.index_valid <= out_side.index_valid;
      rsp.last_pulse  <= out_side.last_pulse;
      rsp.pulse_ticks <= (out_side.setup_ok && out_side.index_valid) ?
                         c2_stg[N2].quot[bpsc_pkg::TICK_W-1:0] : '0;
    end
  end

  // checks
  `BPSC_ASSERT_NOW(a_fail_zero_ticks, rsp.valid && !rsp.setup_ok, rsp.pulse_ticks == '0, "ticks on failed setup")
  `BPSC_ASSERT_NOW(a_last_is_valid, rsp.valid && rsp.last_pulse, rsp.index_valid, "last pulse without valid index")
  `BPSC_ASSERT_NOW(a_ready_tracks_stall, 1'b1, req.ready == !(rsp.valid && !rsp.ready), "ready does not follow output stall")
  `BPSC_ASSERT_NEXT(a_stall_holds_ticks, rsp.valid && !rsp.ready, $stable(rsp.pulse_ticks) && $stable(c2_stg[N2].quot), "chain moved during stall")

endmodule

@@ dv/burst_pulse_schedule_calc_top_tb.sv @@
// self-checking testbench for burst_pulse_schedule_calc_top
// needs bpsc_pkg, bpsc_if and the block's rtl; predicts clock choice and pulse ticks
`timescale 1ns / 1ps

module burst_pulse_schedule_calc_top_tb;

  typedef struct packed {
    logic [bpsc_pkg::F_W-1:0] freq;
    logic [bpsc_pkg::N_W-1:0] count;
    logic [bpsc_pkg::N_W-1:0] index;
  } query_t;

  typedef struct packed {
    logic                        ok;
    logic [bpsc_pkg::SEL_W-1:0]  sel;
    logic [bpsc_pkg::TICK_W-1:0] ticks;
    logic                        valid;
    logic                        last;
  } sched_t;

  localparam int unsigned LATENCY = 65;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ram_we = 1'b0;
  logic [bpsc_pkg::RAM_W-1:0] ram_wdata = '0;

  bpsc_req_if req ();
  bpsc_rsp_if rsp ();

  burst_pulse_schedule_calc_top dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .seq_ram_size_we(ram_we), .seq_ram_size_wdata(ram_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor's own copy of the ram size register
  logic [bpsc_pkg::RAM_W-1:0] ram_size_model;

  query_t pending_q[$];
  sched_t sched_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail_setup = 0;
  int n_fallback = 0;

  function automatic longint unsigned rate_of(int s);
    case (s)
      0, 1, 2: return 64'd4000000;
      3:       return 64'd1000000;
      4:       return 64'd250000;
      default: return 64'd62500;
    endcase
  endfunction

  // clock choice and tick interval for one pulse query
  function automatic sched_t schedule_of(query_t q, logic [bpsc_pkg::RAM_W-1:0] ram);
    sched_t r;
    longint unsigned f, n, k, rt, rs;
    int sel;
    f = q.freq; n = q.count; k = q.index; rs = ram;
    sel = -1;
    r = '0;
    r.valid = (k >= 1) && (k <= n);
    r.last = r.valid && (k == n);
    if (f != 0) begin
      // slowest exact multiple with more than two ticks per pulse
      for (int i = 5; i >= 0; i--) begin
        if (sel < 0 && (rate_of(i) / f) > 2 && (rate_of(i) % f) == 0) sel = i;
      end
      if (sel >= 0 && rate_of(sel) * n > rs * f) sel = -1;
      // else fastest rate that fits
      for (int i = 0; i < 6; i++) begin
        if (sel < 0 && rate_of(i) * n <= rs * f) sel = i;
      end
    end
    if (sel >= 0) begin
      r.ok = 1'b1;
      r.sel = sel[bpsc_pkg::SEL_W-1:0];
      if (r.valid) begin
        rt = rate_of(sel);
        r.ticks = bpsc_pkg::TICK_W'((k * rt) / f - ((k - 1) * rt) / f);
      end
    end
    return r;
  endfunction

  // driver: bursts of offers with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        sched_q.push_back(schedule_of({req.burst_freq, req.pulse_count, req.pulse_index},
                                      ram_size_model));
        n_sent++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          query_t q;
          q = pending_q.pop_front();
          req.valid <= 1'b1;
          {req.burst_freq, req.pulse_count, req.pulse_index} <= q;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(40, 0);
            gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off while the sender keeps offering
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if ($urandom_range(99, 0) == 0) stall_mode <= $urandom_range(2, 0);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(3, 0) != 0);
          default: rsp.ready <= ($urandom_range(1, 0) == 0);
        endcase
      end
    end
  end

  // monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (sched_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        sched_t e;
        e = sched_q.pop_front();
        n_checked++;
        if (!e.ok) n_fail_setup++;
        if (e.ok && e.sel == 0) n_fallback++;
        if (rsp.setup_ok !== e.ok) begin
          $error("setup_ok exp %0d got %0d", e.ok, rsp.setup_ok); errors++;
        end
        if (rsp.clock_sel !== e.sel) begin
          $error("clock_sel exp %0d got %0d", e.sel, rsp.clock_sel); errors++;
        end
        if (rsp.pulse_ticks !== e.ticks) begin
          $error("pulse_ticks exp %0d got %0d", e.ticks, rsp.pulse_ticks); errors++;
        end
        if (rsp.index_valid !== e.valid) begin
          $error("index_valid exp %0d got %0d", e.valid, rsp.index_valid); errors++;
        end
        if (rsp.last_pulse !== e.last) begin
          $error("last_pulse exp %0d got %0d", e.last, rsp.last_pulse); errors++;
        end
      end
    end
  end

  function automatic query_t rand_query();
    query_t q;
    int mode;
    mode = $urandom_range(9, 0);
    case (mode)
      // frequencies built from the rates by shifts and from powers of two and five, aimed at the first-choice path
      0, 1, 2: begin
        int d;
        d = $urandom_range(6, 0);
        q.freq = bpsc_pkg::F_W'(rate_of($urandom_range(5, 3)) >> d);
        if ($urandom_range(1, 0)) begin
          q.freq = bpsc_pkg::F_W'(62500 / (1 << $urandom_range(2, 0)));
        end
        if ($urandom_range(3, 0) == 0) begin
          q.freq = bpsc_pkg::F_W'((1 << $urandom_range(8, 0)) * (5 ** $urandom_range(6, 0)));
        end
      end
      3, 4, 5: q.freq = bpsc_pkg::F_W'($urandom_range(20000, 1));
      6: q.freq = bpsc_pkg::F_W'($urandom());
      default: q.freq = bpsc_pkg::F_W'($urandom_range(1000000, 1));
    endcase
    case ($urandom_range(3, 0))
      0: q.count = bpsc_pkg::N_W'($urandom_range(16, 0));
      1: q.count = bpsc_pkg::N_W'($urandom_range(2000, 1));
      default: q.count = bpsc_pkg::N_W'($urandom());
    endcase
    case ($urandom_range(4, 0))
      0: q.index = bpsc_pkg::N_W'($urandom());
      1: q.index = q.count;
      2: q.index = 16'd1;
      default: q.index = (q.count == 0) ? 16'd0 :
                         bpsc_pkg::N_W'($urandom_range(q.count, 1));
    endcase
    return q;
  endfunction

  task automatic write_ram_size(logic [bpsc_pkg::RAM_W-1:0] v);
    // wait for drained pipeline before touching the register
    while (pending_q.size() > 0 || req.valid || sched_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    ram_we <= 1'b1;
    ram_wdata <= v;
    ram_size_model = v;
    @(posedge clk);
    ram_we <= 1'b0;
  endtask

  initial begin
    logic [bpsc_pkg::RAM_W-1:0] sizes [6];
    ram_size_model = bpsc_pkg::RAM_SIZE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero frequency, zero count, bad index, exact rates
    pending_q.push_back('{20'd0, 16'd10, 16'd1});
    pending_q.push_back('{20'hFFFFF, 16'hFFFF, 16'hFFFF});
    pending_q.push_back('{20'd1, 16'd1, 16'd1});
    pending_q.push_back('{20'd1000000, 16'd100, 16'd100});
    pending_q.push_back('{20'd1000, 16'd0, 16'd0});
    pending_q.push_back('{20'd1000, 16'd5, 16'd0});
    pending_q.push_back('{20'd1000, 16'd5, 16'd6});
    pending_q.push_back('{20'd1000, 16'd5, 16'd5});
    pending_q.push_back('{20'd3, 16'd7, 16'd2});
    pending_q.push_back('{20'd62500, 16'd3, 16'd2});
    pending_q.push_back('{20'd20833, 16'd9, 16'd4});
    pending_q.push_back('{20'd800000, 16'd2, 16'd2});
    pending_q.push_back('{20'd500000, 16'd30, 16'd7});
    pending_q.push_back('{20'd7, 16'd65535, 16'd1});
    pending_q.push_back('{20'd999999, 16'd40000, 16'd39999});
    pending_q.push_back('{20'd250000, 16'd1, 16'd1});

    // ram size settings including both extremes and zero
    sizes = '{16'd1, 16'd65535, 16'd0, 16'd100, 16'd4000, 16'd32760};
    for (int p = 0; p < 6; p++) begin
      write_ram_size(sizes[p]);
      for (int i = 0; i < 230; i++) pending_q.push_back(rand_query());
    end

    while (pending_q.size() > 0 || req.valid || sched_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d queries checked at the reset ram size and 6 written ones", n_checked);
    $display("%0d with no fitting clock, %0d on the fastest fallback rate",
             n_fail_setup, n_fallback);
    if (errors == 0 && sched_q.size() == 0) begin
      $display("burst_pulse_schedule_calc_top_tb: done, clean");
    end else begin
      $display("burst_pulse_schedule_calc_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("burst_pulse_schedule_calc_top_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bpsc_pkg.sv
rtl/core/bpsc_if.sv
rtl/core/bpsc_rate_sel.sv
rtl/core/bpsc_div_cell.sv
rtl/core/burst_pulse_schedule_calc_top.sv
dv/burst_pulse_schedule_calc_top_tb.sv
